### rtl/core/tksp_pkg.sv
// Shared types, constants and lookup functions of the terminal key sequence parser.
package tksp_pkg;

	localparam int MAX_PARAMS  = 4;
	localparam int DIGIT_LIMIT = 256;

	localparam int PARAM_W = 16;
	localparam int PC_W    = $clog2(MAX_PARAMS + 1);
	localparam int DC_W    = $clog2(DIGIT_LIMIT + 1);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ESC   = 3'd1,
		PH_SS3   = 3'd2,
		PH_CSI   = 3'd3,
		PH_PARAM = 3'd4,
		PH_INTER = 3'd5
	} phase_t;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_GAP  = 1'b1;

	localparam logic KIND_KEY     = 1'b0;
	localparam logic KIND_DISCARD = 1'b1;

	localparam logic [4:0] MOD_NONE    = 5'h00;
	localparam logic [4:0] MOD_CONTROL = 5'h04;
	localparam logic [4:0] MOD_SPECIAL = 5'h10;

	localparam logic [7:0] BYTE_ESC      = 8'h1b;
	localparam logic [7:0] BYTE_CTRL_TOP = 8'h1f;
	localparam logic [7:0] BYTE_CTRL_SET = 8'h40;
	localparam logic [7:0] BYTE_SS3      = 8'h4f;
	localparam logic [7:0] BYTE_CSI      = 8'h5b;
	localparam logic [7:0] BYTE_TILDE    = 8'h7e;
	localparam logic [7:0] BYTE_SEMI     = 8'h3b;
	localparam logic [7:0] PARAM_LO      = 8'h30;
	localparam logic [7:0] PARAM_HI      = 8'h3f;
	localparam logic [7:0] INTER_LO      = 8'h20;
	localparam logic [7:0] INTER_HI      = 8'h2f;
	localparam logic [7:0] PF_LO         = 8'h50;
	localparam logic [7:0] PF_HI         = 8'h54;

	// Function-key number for a CSI "n ~" sequence; unlisted codes give zero.
	function automatic logic [7:0] fkey_map(input logic [PARAM_W-1:0] code);
		logic [7:0] key;
		key = 8'd0;
		if (code >= PARAM_W'(10) && code <= PARAM_W'(15)) begin
			key = 8'(code - PARAM_W'(10));
		end else if (code >= PARAM_W'(17) && code <= PARAM_W'(21)) begin
			key = 8'(code - PARAM_W'(11));
		end else if (code == PARAM_W'(23) || code == PARAM_W'(24)) begin
			key = 8'(code - PARAM_W'(12));
		end
		return key;
	endfunction

	// Key value of an escape result.
	function automatic logic [7:0] escape_key(input logic [7:0] val,
			input logic [PARAM_W-1:0] first);
		logic [7:0] key;
		key = val;
		if (val == BYTE_TILDE) begin
			key = fkey_map(first);
		end else if (val >= PF_LO && val <= PF_HI) begin
			key = val - BYTE_SS3;
		end
		return key;
	endfunction

	// Modifiers of an escape result, taken from the second parameter.
	function automatic logic [4:0] escape_mods(input logic [PARAM_W-1:0] second);
		logic [4:0] mods;
		mods = MOD_SPECIAL;
		if (second >= PARAM_W'(2) && second <= PARAM_W'(16)) begin
			mods = MOD_SPECIAL | 5'(second - PARAM_W'(1));
		end
		return mods;
	endfunction

endpackage

### rtl/core/terminal_key_sequence_parser.sv
// Top level of the terminal key sequence parser: byte stream in, key events out.

// The parser takes one terminal byte request per clock on the s_axis side and
// gives at most one key event per request on the m_axis side. A request is held
// in an input register, where short decode logic and the parser state (phase,
// stored CSI parameters, digit accumulator) produce the result, which lands in
// the output register once that register is free; the input register and the
// output register thus lie between a request and its result on m_axis. A new
// request is taken every cycle as long as the output register is empty or
// being drained in the same cycle, so the sustained rate is one request per
// cycle; s_axis_tready follows m_axis_tready combinationally through that
// free-slot check. A gap request (tuser set) closes a pending ESC, ESC O or
// ESC [ prefix as a key event, and gives a discard result while idle or inside
// CSI parameters or intermediates. Control bytes come out with bit 6 set and
// the control flag; escape sequences always carry the special flag with
// modifiers from the second CSI parameter.
module terminal_key_sequence_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [4:0] modifiers, [12:5] key_value, [15:13] zero
	output logic [0:0]  m_axis_tuser    // [0] result_kind
);
	import tksp_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic       gap_s1;
	logic [7:0] byte_s1;

	// Parser state.
	phase_t             phase_q, phase_d;
	logic [PARAM_W-1:0] fp_q, fp_d;
	logic [PARAM_W-1:0] sp_q, sp_d;
	logic [PC_W-1:0]    pc_q, pc_d;
	logic [PARAM_W-1:0] acc_q, acc_d;
	logic [DC_W-1:0]    dc_q, dc_d;

	// Output register.
	logic       out_valid_q;
	logic       out_kind_q;
	logic [4:0] out_mods_q;
	logic [7:0] out_key_q;

	logic       out_free;
	logic       advance;
	logic       res_valid;
	logic       res_kind;
	logic [4:0] res_mods;
	logic [7:0] res_key;
	logic       do_esc;
	logic [7:0] esc_val;
	logic       do_param;
	logic       is_param;
	logic       is_inter;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	assign is_param = (byte_s1 >= PARAM_LO) && (byte_s1 <= PARAM_HI);
	assign is_inter = (byte_s1 >= INTER_LO) && (byte_s1 <= INTER_HI);

	always_comb begin
		phase_d   = phase_q;
		fp_d      = fp_q;
		sp_d      = sp_q;
		pc_d      = pc_q;
		acc_d     = acc_q;
		dc_d      = dc_q;
		res_valid = 1'b0;
		res_kind  = KIND_KEY;
		res_mods  = MOD_NONE;
		res_key   = 8'd0;
		do_esc    = 1'b0;
		esc_val   = 8'd0;
		do_param  = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (gap_s1 == REQ_GAP) begin
					res_valid = 1'b1;
					res_kind  = KIND_DISCARD;
				end else if (byte_s1 == BYTE_ESC) begin
					phase_d = PH_ESC;
				end else if (byte_s1 <= BYTE_CTRL_TOP) begin
					res_valid = 1'b1;
					res_mods  = MOD_CONTROL;
					res_key   = byte_s1 | BYTE_CTRL_SET;
				end else begin
					res_valid = 1'b1;
					res_key   = byte_s1;
				end
			end
			PH_ESC: begin
				if (gap_s1 == REQ_GAP || byte_s1 == BYTE_ESC) begin
					do_esc  = 1'b1;
					esc_val = BYTE_ESC;
				end else if (byte_s1 == BYTE_SS3) begin
					phase_d = PH_SS3;
				end else if (byte_s1 == BYTE_CSI) begin
					phase_d = PH_CSI;
				end else begin
					do_esc  = 1'b1;
					esc_val = byte_s1;
				end
			end
			PH_SS3: begin
				do_esc  = 1'b1;
				esc_val = (gap_s1 == REQ_GAP) ? BYTE_SS3 : byte_s1 - BYTE_SS3;
			end
			PH_CSI: begin
				if (gap_s1 == REQ_GAP) begin
					do_esc  = 1'b1;
					esc_val = BYTE_CSI;
				end else if (is_param) begin
					do_param = 1'b1;
				end else if (is_inter) begin
					phase_d = PH_INTER;
				end else begin
					do_esc  = 1'b1;
					esc_val = byte_s1;
				end
			end
			PH_PARAM: begin
				if (gap_s1 == REQ_GAP) begin
					res_valid = 1'b1;
					res_kind  = KIND_DISCARD;
				end else begin
					do_param = 1'b1;
				end
			end
			PH_INTER: begin
				if (gap_s1 == REQ_GAP) begin
					res_valid = 1'b1;
					res_kind  = KIND_DISCARD;
				end else if (!is_inter) begin
					do_esc  = 1'b1;
					esc_val = byte_s1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				fp_d    = '0;
				sp_d    = '0;
				pc_d    = '0;
				acc_d   = '0;
				dc_d    = '0;
			end
		endcase

		// A byte inside the parameters either extends the current number or closes it.
		if (do_param) begin
			phase_d = PH_PARAM;
			if (is_param && byte_s1 != BYTE_SEMI) begin
				if (dc_q < DC_W'(DIGIT_LIMIT)) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + PARAM_W'(byte_s1[3:0]);
					dc_d  = dc_q + DC_W'(1);
				end
			end else begin
				if (pc_q < PC_W'(MAX_PARAMS)) begin
					if (pc_q == PC_W'(0)) begin
						fp_d = acc_q;
					end else if (pc_q == PC_W'(1)) begin
						sp_d = acc_q;
					end
					pc_d  = pc_q + PC_W'(1);
					acc_d = '0;
					dc_d  = '0;
				end
				if (!is_param) begin
					phase_d = PH_INTER;
					if (!is_inter) begin
						do_esc  = 1'b1;
						esc_val = byte_s1;
					end
				end
			end
		end

		// The final byte sees the parameters as just stored.
		if (do_esc) begin
			res_valid = 1'b1;
			res_mods  = escape_mods(sp_d);
			res_key   = escape_key(esc_val, fp_d);
		end

		// Every key event returns the parser to a clean idle.
		if (res_valid && res_kind == KIND_KEY) begin
			phase_d = PH_IDLE;
			fp_d    = '0;
			sp_d    = '0;
			pc_d    = '0;
			acc_d   = '0;
			dc_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			gap_s1  <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fp_q    <= '0;
			sp_q    <= '0;
			pc_q    <= '0;
			acc_q   <= '0;
			dc_q    <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			fp_q    <= fp_d;
			sp_q    <= sp_d;
			pc_q    <= pc_d;
			acc_q   <= acc_d;
			dc_q    <= dc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_q <= res_kind;
			out_mods_q <= res_mods;
			out_key_q  <= res_key;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_key_q, out_mods_q};
	assign m_axis_tuser  = out_kind_q;

	// A discard never carries a key or modifiers.
	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_DISCARD |-> out_mods_q == MOD_NONE && out_key_q == 8'd0)
		else $error("discard result with nonzero payload");

	// A key event leaves the parser idle with all parameters cleared.
	a_key_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_kind == KIND_KEY |=>
			phase_q == PH_IDLE && pc_q == '0 && fp_q == '0 && sp_q == '0)
		else $error("parser state not cleared after key event");

	// A held request is never dropped while the output side stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(gap_s1))
		else $error("stalled request lost from input register");

	// The stored parameter count never passes its limit.
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pc_q <= PC_W'(MAX_PARAMS))
		else $error("parameter count past limit");

endmodule
